FILE: src/glzw_pkg.sv
// Shared types, codes and constants of the GIF LZW back-reference decoder.
package glzw_pkg;

  localparam int unsigned CFG_W  = 4;
  localparam int unsigned CW_W   = 4;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned NRES_W = 2;

  localparam logic [CFG_W-1:0]  MIN_SIZE_RESET = 4'd8;
  localparam logic [CFG_W-1:0]  MIN_SIZE_LOW   = 4'd2;
  localparam logic [CFG_W-1:0]  MIN_SIZE_HIGH  = 4'd8;
  localparam logic [NRES_W-1:0] MAX_RESULTS    = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LITERAL,
    OP_TABLE,
    OP_KWKWK,
    OP_STOP,
    OP_INVALID
  } code_op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_LITERAL  = 3'd0,
    KIND_COPY     = 3'd1,
    KIND_END      = 3'd2,
    KIND_INVALID  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } res_kind_e;

  typedef struct packed {
    code_op_e   op;
    logic       add;
    logic       restart;
    logic       byte_end;
    logic [7:0] color;
  } item_ctl_t;

  function automatic logic [CFG_W-1:0] eff_min_size(input logic [CFG_W-1:0] cfg);
    logic [CFG_W-1:0] res;
    res = cfg;
    if (cfg < MIN_SIZE_LOW) begin
      res = MIN_SIZE_LOW;
    end else if (cfg > MIN_SIZE_HIGH) begin
      res = MIN_SIZE_HIGH;
    end
    return res;
  endfunction

endpackage

FILE: src/glzw_code_unpacker.sv
// Bit unpacker and code classifier: one code per cycle while the copy stage accepts items, with dictionary bookkeeping.
module glzw_code_unpacker import glzw_pkg::*; #(
  parameter int unsigned MAX_CODE_BITS = 12,
  parameter int unsigned TABLE_ENTRIES = 4096,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] min_code_size_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             start_image_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output item_ctl_t        item_ctl_o,
  output logic [IDX_W-1:0] rd_idx_o,
  output logic [IDX_W-1:0] wr_idx_o
);

  localparam int unsigned EC_W  = IDX_W + 1;
  localparam int unsigned CMP_W = ((MAX_CODE_BITS > IDX_W) ? MAX_CODE_BITS : IDX_W) + 1;
  localparam int unsigned BUF_W = MAX_CODE_BITS + 8;
  localparam int unsigned CNT_W = $clog2(BUF_W + 1);
  localparam logic [CW_W-1:0] CW_RESET = MIN_SIZE_RESET + 4'd1;

  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CW_W-1:0]   cw_q, cw_d;
  logic [EC_W-1:0]   ec_q, ec_d;
  logic [NRES_W-1:0] nres_q, nres_d;
  logic              ac_q, ac_d;
  logic              stopped_q, stopped_d;
  logic              restart_q, restart_d;

  logic [CFG_W-1:0]         eff;
  logic [CMP_W-1:0]         code_clr, code_eoi, next_code, pow_w, code;
  logic [MAX_CODE_BITS-1:0] code_mask;
  logic                     full, code_avail, work, byte_end, issue_fire, in_fire;

  always_comb begin
    logic [BUF_W-1:0]  p_buf;
    logic [CNT_W-1:0]  p_cnt;
    logic [CW_W-1:0]   p_cw;
    logic [EC_W-1:0]   p_ec;
    logic [NRES_W-1:0] p_nres;
    logic              p_ac;
    logic              p_stopped;
    code_op_e          op;
    logic              add;

    eff        = eff_min_size(min_code_size_i);
    code_clr   = CMP_W'(1) << eff;
    code_eoi   = code_clr + CMP_W'(1);
    next_code  = code_clr + CMP_W'(2) + CMP_W'(ec_q);
    full       = next_code >= CMP_W'(TABLE_ENTRIES);
    pow_w      = CMP_W'(1) << cw_q;
    code_mask  = ~({MAX_CODE_BITS{1'b1}} << cw_q);
    code       = CMP_W'(buf_q[MAX_CODE_BITS-1:0] & code_mask);
    code_avail = !stopped_q && (cnt_q >= CNT_W'(cw_q)) && (nres_q < MAX_RESULTS);
    work       = restart_q || code_avail;

    p_buf     = buf_q;
    p_cnt     = cnt_q;
    p_cw      = cw_q;
    p_ec      = ec_q;
    p_nres    = nres_q;
    p_ac      = ac_q;
    p_stopped = stopped_q;
    op        = OP_NONE;
    add       = 1'b0;

    if (code_avail) begin
      p_buf  = buf_q >> cw_q;
      p_cnt  = cnt_q - CNT_W'(cw_q);
      p_nres = nres_q + NRES_W'(1);
      if (code == code_clr) begin
        op     = OP_CLEAR;
        p_ec   = '0;
        p_cw   = eff + 4'd1;
        p_ac   = 1'b1;
        p_nres = nres_q;
      end else if (code == code_eoi) begin
        op        = OP_STOP;
        p_stopped = 1'b1;
      end else if (code < code_clr) begin
        op = OP_LITERAL;
      end else if (code < next_code) begin
        op = OP_TABLE;
      end else if ((code == next_code) && !ac_q && !full) begin
        op = OP_KWKWK;
      end else begin
        op        = OP_INVALID;
        p_stopped = 1'b1;
      end
      if ((op == OP_LITERAL) || (op == OP_TABLE) || (op == OP_KWKWK)) begin
        if (!ac_q && !full) begin
          add  = 1'b1;
          p_ec = ec_q + EC_W'(1);
          if ((cw_q < CW_W'(MAX_CODE_BITS)) && ((next_code + CMP_W'(1)) == pow_w) &&
              (pow_w < CMP_W'(TABLE_ENTRIES))) begin
            p_cw = cw_q + 4'd1;
          end
        end
        p_ac = 1'b0;
      end
      if (p_stopped) begin
        p_buf = '0;
        p_cnt = '0;
      end
    end

    byte_end = !(!p_stopped && (p_cnt >= CNT_W'(p_cw)) && (p_nres < MAX_RESULTS));

    item_valid_o        = work;
    item_ctl_o.op       = op;
    item_ctl_o.add      = add;
    item_ctl_o.restart  = restart_q;
    item_ctl_o.byte_end = byte_end;
    item_ctl_o.color    = code[7:0];
    rd_idx_o            = IDX_W'(code - code_clr - CMP_W'(2));
    wr_idx_o            = IDX_W'(ec_q);

    issue_fire = work && item_ready_i;
    in_ready_o = !work || (item_ready_i && byte_end);
    in_fire    = in_valid_i && in_ready_o;

    buf_d     = buf_q;
    cnt_d     = cnt_q;
    cw_d      = cw_q;
    ec_d      = ec_q;
    nres_d    = nres_q;
    ac_d      = ac_q;
    stopped_d = stopped_q;
    restart_d = restart_q;

    if (issue_fire) begin
      buf_d     = p_buf;
      cnt_d     = p_cnt;
      cw_d      = p_cw;
      ec_d      = p_ec;
      nres_d    = p_nres;
      ac_d      = p_ac;
      stopped_d = p_stopped;
      restart_d = 1'b0;
    end

    if (in_fire) begin
      if (start_image_i) begin
        buf_d     = '0;
        cnt_d     = '0;
        cw_d      = eff + 4'd1;
        ec_d      = '0;
        ac_d      = 1'b1;
        stopped_d = 1'b0;
        restart_d = 1'b1;
      end
      nres_d = '0;
      if (!stopped_d) begin
        buf_d = buf_d | (BUF_W'(data_byte_i) << cnt_d);
        cnt_d = cnt_d + CNT_W'(8);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q     <= '0;
      cnt_q     <= '0;
      cw_q      <= CW_RESET;
      ec_q      <= '0;
      nres_q    <= '0;
      ac_q      <= 1'b1;
      stopped_q <= 1'b0;
      restart_q <= 1'b0;
    end else begin
      buf_q     <= buf_d;
      cnt_q     <= cnt_d;
      cw_q      <= cw_d;
      ec_q      <= ec_d;
      nres_q    <= nres_d;
      ac_q      <= ac_d;
      stopped_q <= stopped_d;
      restart_q <= restart_d;
    end
  end

endmodule

FILE: src/glzw_copy_gen.sv
// Dictionary memory and copy stage: reads entries, forms results, appends new entries.
module glzw_copy_gen import glzw_pkg::*; #(
  parameter int unsigned POS_BITS      = 20,
  parameter int unsigned TABLE_ENTRIES = 4096,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  item_ctl_t           item_ctl_i,
  input  logic [IDX_W-1:0]    rd_idx_i,
  input  logic [IDX_W-1:0]    wr_idx_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [KIND_W-1:0]   res_kind_o,
  output logic [7:0]          res_color_o,
  output logic [POS_BITS-1:0] res_src_o,
  output logic [LEN_W-1:0]    res_len_o,
  output logic [POS_BITS-1:0] res_dest_o,
  output logic                res_final_o,
  output logic                mark_o
);

  localparam int unsigned ENT_W = POS_BITS + LEN_W;
  localparam int unsigned SUM_W = ((POS_BITS > LEN_W) ? POS_BITS : LEN_W) + 1;

  logic [ENT_W-1:0] entry_mem [TABLE_ENTRIES];

  logic                e_valid_q;
  item_ctl_t           ctl_q;
  logic [IDX_W-1:0]    widx_q;
  logic [ENT_W-1:0]    rdata_q;
  logic                fwd_q;
  logic [ENT_W-1:0]    fwd_data_q;
  logic [POS_BITS-1:0] prev_start_q, prev_start_d;
  logic [LEN_W-1:0]    prev_len_q, prev_len_d;
  logic [POS_BITS-1:0] wpos_q, wpos_d;
  logic                stopped_q, stopped_d;

  logic                go, wr_en;
  logic [ENT_W-1:0]    wdata;

  always_comb begin
    logic [POS_BITS-1:0] b_start;
    logic [LEN_W-1:0]    b_len;
    logic [POS_BITS-1:0] b_wpos;
    logic                b_stopped;
    logic [ENT_W-1:0]    ent;
    logic [LEN_W-1:0]    kw_len;
    logic [LEN_W-1:0]    len;
    logic [POS_BITS-1:0] src;
    logic [SUM_W-1:0]    sum;
    logic                live, is_data, ovf, emit;
    res_kind_e           kind;

    b_start   = ctl_q.restart ? '0 : prev_start_q;
    b_len     = ctl_q.restart ? '0 : prev_len_q;
    b_wpos    = ctl_q.restart ? '0 : wpos_q;
    b_stopped = ctl_q.restart ? 1'b0 : stopped_q;

    ent    = fwd_q ? fwd_data_q : rdata_q;
    kw_len = b_len + LEN_W'(1);
    live   = e_valid_q && !b_stopped;

    len     = '0;
    src     = '0;
    is_data = 1'b0;
    emit    = 1'b0;
    kind    = KIND_LITERAL;
    case (ctl_q.op)
      OP_LITERAL: begin
        len     = LEN_W'(1);
        is_data = 1'b1;
        kind    = KIND_LITERAL;
      end
      OP_TABLE: begin
        src     = ent[ENT_W-1:LEN_W];
        len     = ent[LEN_W-1:0];
        is_data = 1'b1;
        kind    = KIND_COPY;
      end
      OP_KWKWK: begin
        src     = b_start;
        len     = kw_len;
        is_data = 1'b1;
        kind    = KIND_COPY;
      end
      OP_STOP: begin
        emit = 1'b1;
        kind = KIND_END;
      end
      OP_INVALID: begin
        emit = 1'b1;
        kind = KIND_INVALID;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    sum = SUM_W'(b_wpos) + SUM_W'(len);
    ovf = |(sum >> POS_BITS);
    if (is_data) begin
      emit = 1'b1;
      if (ovf) begin
        kind = KIND_OVERFLOW;
      end
    end
    emit = emit && live;

    res_valid_o = e_valid_q && emit;
    res_kind_o  = kind;
    res_color_o = (kind == KIND_LITERAL) ? ctl_q.color : 8'd0;
    res_src_o   = (kind == KIND_COPY) ? src : '0;
    res_len_o   = ((kind == KIND_LITERAL) || (kind == KIND_COPY)) ? len : '0;
    res_dest_o  = b_wpos;
    res_final_o = ctl_q.byte_end || (kind == KIND_END) || (kind == KIND_INVALID) ||
                  (kind == KIND_OVERFLOW);

    go           = e_valid_q && (!emit || res_ready_i);
    item_ready_o = !e_valid_q || go;
    mark_o       = go && !emit && ctl_q.byte_end;
    wr_en        = go && live && ctl_q.add;
    wdata        = {b_start, kw_len};

    prev_start_d = prev_start_q;
    prev_len_d   = prev_len_q;
    wpos_d       = wpos_q;
    stopped_d    = stopped_q;
    if (go) begin
      prev_start_d = b_start;
      prev_len_d   = b_len;
      wpos_d       = b_wpos;
      stopped_d    = b_stopped;
      if (live) begin
        if (is_data && !ovf) begin
          prev_start_d = b_wpos;
          prev_len_d   = len;
          wpos_d       = sum[POS_BITS-1:0];
        end else if (emit) begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[widx_q] <= wdata;
    end
    if (item_ready_o) begin
      rdata_q    <= entry_mem[rd_idx_i];
      ctl_q      <= item_ctl_i;
      widx_q     <= wr_idx_i;
      fwd_q      <= wr_en && (widx_q == rd_idx_i);
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q    <= 1'b0;
      prev_start_q <= '0;
      prev_len_q   <= '0;
      wpos_q       <= '0;
      stopped_q    <= 1'b0;
    end else begin
      if (item_ready_o) begin
        e_valid_q <= item_valid_i;
      end
      prev_start_q <= prev_start_d;
      prev_len_q   <= prev_len_d;
      wpos_q       <= wpos_d;
      stopped_q    <= stopped_d;
    end
  end

endmodule

FILE: src/glzw_result_buf.sv
// Result hold stage that settles the last flag, followed by the output register.
module glzw_result_buf import glzw_pkg::*; #(
  parameter int unsigned POS_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  output logic                res_ready_o,
  input  logic [KIND_W-1:0]   res_kind_i,
  input  logic [7:0]          res_color_i,
  input  logic [POS_BITS-1:0] res_src_i,
  input  logic [LEN_W-1:0]    res_len_i,
  input  logic [POS_BITS-1:0] res_dest_i,
  input  logic                res_final_i,
  input  logic                mark_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KIND_W-1:0]   kind_o,
  output logic [7:0]          color_index_o,
  output logic [POS_BITS-1:0] source_pos_o,
  output logic [LEN_W-1:0]    copy_length_o,
  output logic [POS_BITS-1:0] dest_pos_o,
  output logic                last_o
);

  logic                h_valid_q, h_final_q;
  logic [KIND_W-1:0]   h_kind_q;
  logic [7:0]          h_color_q;
  logic [POS_BITS-1:0] h_src_q, h_dest_q;
  logic [LEN_W-1:0]    h_len_q;

  logic                o_valid_q, o_last_q;
  logic [KIND_W-1:0]   o_kind_q;
  logic [7:0]          o_color_q;
  logic [POS_BITS-1:0] o_src_q, o_dest_q;
  logic [LEN_W-1:0]    o_len_q;

  logic o_free, h_move, res_take;

  assign o_free      = !o_valid_q || out_ready_i;
  assign h_move      = h_valid_q && o_free && (h_final_q || res_valid_i);
  assign res_ready_o = !h_valid_q || h_move;
  assign res_take    = res_valid_i && res_ready_o;

  assign out_valid_o   = o_valid_q;
  assign kind_o        = o_kind_q;
  assign color_index_o = o_color_q;
  assign source_pos_o  = o_src_q;
  assign copy_length_o = o_len_q;
  assign dest_pos_o    = o_dest_q;
  assign last_o        = o_last_q;

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      h_kind_q  <= res_kind_i;
      h_color_q <= res_color_i;
      h_src_q   <= res_src_i;
      h_len_q   <= res_len_i;
      h_dest_q  <= res_dest_i;
    end
    if (h_move) begin
      o_kind_q  <= h_kind_q;
      o_color_q <= h_color_q;
      o_src_q   <= h_src_q;
      o_len_q   <= h_len_q;
      o_dest_q  <= h_dest_q;
      o_last_q  <= h_final_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
      h_final_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (res_take) begin
        h_valid_q <= 1'b1;
        h_final_q <= res_final_i;
      end else if (h_move) begin
        h_valid_q <= 1'b0;
      end else if (mark_i && h_valid_q) begin
        h_final_q <= 1'b1;
      end
      if (h_move) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: src/gif_lzw_backref_decoder.sv
// Top level of the GIF LZW back-reference decoder.
// The decoder unpacks LSB-first LZW codes from the byte stream at one code per clock cycle
// while the copy stage accepts them, so a byte is accepted once the codes that the bits already
// held allow have been issued; results flow out at one per cycle while the output is ready. The rate is set by
// the code unpacker, which finishes one code a cycle, and the dictionary memory, whose
// registered read is hidden by a second stage with forwarding of the entry written just before.
// A result passes the copy stage, a hold stage and the output register; the hold stage keeps
// it until the byte's last code is known. The dictionary memory needs no clearing after reset.
module gif_lzw_backref_decoder import glzw_pkg::*; #(
  parameter int unsigned MAX_CODE_BITS = 12,
  parameter int unsigned POS_BITS      = 20,
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                start_image_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KIND_W-1:0]   kind_o,
  output logic [7:0]          color_index_o,
  output logic [POS_BITS-1:0] source_pos_o,
  output logic [LEN_W-1:0]    copy_length_o,
  output logic [POS_BITS-1:0] dest_pos_o,
  output logic                last_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  logic [CFG_W-1:0]    min_code_size_q;
  logic                item_valid, item_ready;
  item_ctl_t           item_ctl;
  logic [IDX_W-1:0]    rd_idx, wr_idx;
  logic                res_valid, res_ready, res_final, mark;
  logic [KIND_W-1:0]   res_kind;
  logic [7:0]          res_color;
  logic [POS_BITS-1:0] res_src, res_dest;
  logic [LEN_W-1:0]    res_len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_code_size_q <= MIN_SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_code_size_q <= cfg_data_i;
    end
  end

  glzw_code_unpacker #(
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_unpacker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .min_code_size_i(min_code_size_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .start_image_i  (start_image_i),
    .item_valid_o   (item_valid),
    .item_ready_i   (item_ready),
    .item_ctl_o     (item_ctl),
    .rd_idx_o       (rd_idx),
    .wr_idx_o       (wr_idx)
  );

  glzw_copy_gen #(
    .POS_BITS     (POS_BITS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_copy_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .item_ctl_i  (item_ctl),
    .rd_idx_i    (rd_idx),
    .wr_idx_i    (wr_idx),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_kind_o  (res_kind),
    .res_color_o (res_color),
    .res_src_o   (res_src),
    .res_len_o   (res_len),
    .res_dest_o  (res_dest),
    .res_final_o (res_final),
    .mark_o      (mark)
  );

  glzw_result_buf #(
    .POS_BITS(POS_BITS)
  ) u_result_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_kind_i   (res_kind),
    .res_color_i  (res_color),
    .res_src_i    (res_src),
    .res_len_i    (res_len),
    .res_dest_i   (res_dest),
    .res_final_i  (res_final),
    .mark_i       (mark),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .color_index_o(color_index_o),
    .source_pos_o (source_pos_o),
    .copy_length_o(copy_length_o),
    .dest_pos_o   (dest_pos_o),
    .last_o       (last_o)
  );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the GIF LZW back-reference decoder.
`timescale 1ns / 1ps

module tb_top;
  import glzw_pkg::*;

  localparam int unsigned POS_W = 20;
  localparam int unsigned CODE_BITS = 12;
  localparam int unsigned TBL_DEPTH = 4096;
  localparam int unsigned POS_MAX = (1 << POS_W) - 1;
  localparam int unsigned LIMIT = 600000;
  localparam int unsigned SETTLE = 12;
  localparam int unsigned RANDOM_BYTES = 280;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_CFG [PHASES] = '{2, 15, 0, 5, 8, 0};

  typedef struct {
    res_kind_e          kind;
    logic [7:0]         color;
    logic [POS_W-1:0]   src;
    logic [LEN_W-1:0]   len;
    logic [POS_W-1:0]   dest;
    logic               last;
  } pix_cmd_t;

  class backref_scoreboard;
    int unsigned size_reg;
    int unsigned bit_acc;
    int unsigned bit_fill;
    int unsigned width;
    int unsigned n_dict;
    int unsigned last_start;
    int unsigned last_len;
    int unsigned pix_pos;
    bit          fresh_clear;
    bit          halted;
    int unsigned dict_start [TBL_DEPTH];
    int unsigned dict_len [TBL_DEPTH];
    pix_cmd_t    want_cmds [$];
    int unsigned checked = 0;
    int unsigned errors = 0;

    static function int unsigned clamp_size(int unsigned v);
      if (v < 2) return 2;
      if (v > 8) return 8;
      return v;
    endfunction

    function new();
      size_reg = MIN_SIZE_RESET;
      restart();
    endfunction

    function void restart();
      bit_acc = 0;
      bit_fill = 0;
      width = clamp_size(size_reg) + 1;
      n_dict = 0;
      last_start = 0;
      last_len = 0;
      pix_pos = 0;
      fresh_clear = 1'b1;
      halted = 1'b0;
    endfunction

    function void set_size(int unsigned v);
      size_reg = v & 'hF;
    endfunction

    function int unsigned pending();
      return want_cmds.size();
    endfunction

    function pix_cmd_t cmd(res_kind_e k, int unsigned col, int unsigned src,
                           int unsigned len, int unsigned dest);
      pix_cmd_t c;
      c.kind = k;
      c.color = col[7:0];
      c.src = src[POS_W-1:0];
      c.len = len[LEN_W-1:0];
      c.dest = dest[POS_W-1:0];
      c.last = 1'b0;
      return c;
    endfunction

    // Works out the decoder commands that one accepted byte produces.
    function void note_byte(logic [7:0] d, logic s);
      pix_cmd_t    got [$];
      res_kind_e   k;
      int unsigned sz, clr, cap, nxt, code, col, src, len;
      bit          ok;
      if (s) restart();
      if (halted) return;
      bit_acc |= 32'(d) << bit_fill;
      bit_fill += 8;
      while (!halted && got.size() < MAX_RESULTS && bit_fill >= width) begin
        sz = clamp_size(size_reg);
        clr = 1 << sz;
        cap = TBL_DEPTH - clr - 2;
        nxt = clr + 2 + n_dict;
        code = bit_acc & ((1 << width) - 1);
        bit_acc >>= width;
        bit_fill -= width;
        if (code == clr) begin
          n_dict = 0;
          width = sz + 1;
          fresh_clear = 1'b1;
        end else if (code == clr + 1) begin
          got.push_back(cmd(KIND_END, 0, 0, 0, pix_pos));
          halted = 1'b1;
        end else begin
          ok = 1'b1;
          col = 0;
          src = 0;
          len = 0;
          k = KIND_COPY;
          if (code < clr) begin
            k = KIND_LITERAL;
            col = code;
            len = 1;
          end else if (code < nxt) begin
            src = dict_start[code - clr - 2];
            len = dict_len[code - clr - 2];
          end else if (code == nxt && !fresh_clear && n_dict < cap) begin
            src = last_start;
            len = (last_len + 1) & 'h1FFF;
          end else begin
            got.push_back(cmd(KIND_INVALID, 0, 0, 0, pix_pos));
            halted = 1'b1;
            ok = 1'b0;
          end
          if (ok && pix_pos + len > POS_MAX) begin
            got.push_back(cmd(KIND_OVERFLOW, 0, 0, 0, pix_pos));
            halted = 1'b1;
            ok = 1'b0;
          end
          if (ok) begin
            got.push_back(cmd(k, col, src, len, pix_pos));
            if (!fresh_clear && n_dict < cap) begin
              dict_start[n_dict] = last_start;
              dict_len[n_dict] = (last_len + 1) & 'h1FFF;
              n_dict++;
              if (width < CODE_BITS && clr + 2 + n_dict == (1 << width) &&
                  (1 << width) < TBL_DEPTH) begin
                width++;
              end
            end
            last_start = pix_pos;
            last_len = len;
            pix_pos = (pix_pos + len) & POS_MAX;
            fresh_clear = 1'b0;
          end
        end
      end
      if (halted) begin
        bit_acc = 0;
        bit_fill = 0;
      end
      if (got.size() > 0) got[got.size() - 1].last = 1'b1;
      foreach (got[i]) want_cmds.push_back(got[i]);
    endfunction

    function void check_cmd(logic [KIND_W-1:0] kind, logic [7:0] col,
                            logic [POS_W-1:0] src, logic [LEN_W-1:0] len,
                            logic [POS_W-1:0] dest, logic last);
      pix_cmd_t w;
      checked++;
      if (want_cmds.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result: kind %0d color %0d src %0d len %0d dest %0d last %0d",
                   kind, col, src, len, dest, last);
        end
        return;
      end
      w = want_cmds.pop_front();
      if (kind !== w.kind || col !== w.color || src !== w.src || len !== w.len ||
          dest !== w.dest || last !== w.last) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: expected kind %0d color %0d src %0d len %0d dest %0d last %0d",
                   w.kind, w.color, w.src, w.len, w.dest, w.last);
          $display("          got      kind %0d color %0d src %0d len %0d dest %0d last %0d",
                   kind, col, src, len, dest, last);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          data_byte = '0;
  logic                start_image = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [7:0]          color_index;
  logic [POS_W-1:0]    source_pos;
  logic [LEN_W-1:0]    copy_length;
  logic [POS_W-1:0]    dest_pos;
  logic                last;

  backref_scoreboard sb = new();
  bit                idle_on = 1'b1;
  int unsigned       cycles = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       images = 0;
  int unsigned       settings = 0;
  int unsigned       cfg_shadow = MIN_SIZE_RESET;

  int unsigned       gen_size;
  int unsigned       gen_entries;
  int unsigned       gen_width;
  bit                gen_fresh;
  logic [31:0]       gen_acc;
  int unsigned       gen_fill;
  logic [7:0]        byte_q [$];

  gif_lzw_backref_decoder #(
    .MAX_CODE_BITS(CODE_BITS),
    .POS_BITS(POS_W),
    .TABLE_ENTRIES(TBL_DEPTH)
  ) u_dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .data_byte_i(data_byte),
    .start_image_i(start_image),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .kind_o(kind),
    .color_index_o(color_index),
    .source_pos_o(source_pos),
    .copy_length_o(copy_length),
    .dest_pos_o(dest_pos),
    .last_o(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_cmd(kind, color_index, source_pos, copy_length, dest_pos, last);
    end
  end

  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int unsigned gen_next();
    return (1 << gen_size) + 2 + gen_entries;
  endfunction

  function automatic void code_begin();
    gen_size = backref_scoreboard::clamp_size(cfg_shadow);
    gen_entries = 0;
    gen_width = gen_size + 1;
    gen_fresh = 1'b1;
    gen_acc = '0;
    gen_fill = 0;
    byte_q.delete();
  endfunction

  // Packs one code at the width the decoder will use and tracks its dictionary growth.
  function automatic void put_code(int unsigned code);
    int unsigned clr;
    clr = 1 << gen_size;
    gen_acc |= (code & ((1 << gen_width) - 1)) << gen_fill;
    gen_fill += gen_width;
    while (gen_fill >= 8) begin
      byte_q.push_back(gen_acc[7:0]);
      gen_acc >>= 8;
      gen_fill -= 8;
    end
    if (code == clr) begin
      gen_entries = 0;
      gen_width = gen_size + 1;
      gen_fresh = 1'b1;
    end else if (code != clr + 1) begin
      if (!gen_fresh && gen_entries < TBL_DEPTH - clr - 2) begin
        gen_entries++;
        if (gen_width < CODE_BITS && clr + 2 + gen_entries == (1 << gen_width) &&
            (1 << gen_width) < TBL_DEPTH) begin
          gen_width++;
        end
      end
      gen_fresh = 1'b0;
    end
  endfunction

  function automatic void code_end();
    logic [31:0] pad;
    if (gen_fill > 0) begin
      pad = gen_acc | ($urandom << gen_fill);
      byte_q.push_back(pad[7:0]);
    end
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    start_image <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(d, s);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_codes();
    foreach (byte_q[i]) send_byte(byte_q[i], i == 0);
    images++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_min_size(input int unsigned v);
    cfg_valid <= 1'b1;
    cfg_data <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_size(v);
    cfg_shadow = v & 'hF;
    settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_image();
    int unsigned clr, n, r, top;
    code_begin();
    clr = 1 << gen_size;
    if ($urandom_range(0, 1) == 1) put_code(clr);
    n = $urandom_range(2, 40);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        put_code(clr);
      end else if (r >= 45 && r < 75 && gen_entries > 0) begin
        put_code($urandom_range(clr + 2, gen_next() - 1));
      end else if (r >= 75 && !gen_fresh) begin
        put_code(gen_next());
      end else begin
        put_code($urandom_range(0, clr - 1));
      end
    end
    r = $urandom_range(0, 99);
    top = (1 << gen_width) - 1;
    if (r < 76) begin
      put_code(clr + 1);
    end else if (r < 88 && gen_next() < top) begin
      put_code($urandom_range(gen_next() + 1, top));
    end else if (r < 94) begin
      put_code(clr + 1);
      repeat ($urandom_range(1, 4)) put_code($urandom_range(0, clr - 1));
    end
    code_end();
    send_codes();
  endtask

  task automatic noise_image();
    byte_q.delete();
    repeat ($urandom_range(1, 6)) byte_q.push_back(8'($urandom));
    send_codes();
  endtask

  initial begin
    int unsigned p, setting, clr;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    code_begin();
    clr = 1 << gen_size;
    put_code(clr);
    put_code(0);
    put_code(clr - 1);
    put_code(gen_next());
    put_code(clr + 2);
    put_code(clr);
    put_code(7);
    put_code(clr + 1);
    code_end();
    byte_q.push_back(8'h5A);
    send_codes();
    code_begin();
    put_code(gen_next());
    code_end();
    send_codes();
    code_begin();
    put_code(5);
    put_code(gen_next() + 1);
    code_end();
    send_codes();
    settle();
    write_min_size(MIN_SIZE_LOW);
    code_begin();
    clr = 1 << gen_size;
    put_code(clr);
    put_code(clr - 1);
    repeat (8) put_code(gen_next());
    put_code(clr + 1);
    code_end();
    send_codes();

    for (p = 0; p < PHASES; p++) begin
      setting = PHASE_CFG[p];
      if (p == PHASES - 1) begin
        idle_on = 1'b0;
        setting = $urandom_range(0, 15);
      end
      settle();
      write_min_size(setting);
      while (bytes_sent < (p + 1) * RANDOM_BYTES / PHASES) begin
        if ($urandom_range(0, 6) == 0) begin
          noise_image();
        end else begin
          random_image();
        end
      end
    end

    settle();
    $display("Sent %0d code bytes in %0d images under %0d code-size settings,",
             bytes_sent, images, settings);
    $display("with clears, copies, run-on codes, ends and bad codes; %0d results, %0d bad.",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: gif_lzw_backref_decoder.f
src/glzw_pkg.sv
src/glzw_code_unpacker.sv
src/glzw_copy_gen.sv
src/glzw_result_buf.sv
src/gif_lzw_backref_decoder.sv
dv/tb_top.sv
